// ===== design/trvc_pkg.sv =====
// Shared constants, types and helpers of the tensor reshape view check.
package trvc_pkg;

  localparam int NUM_DIMS = 4;
  localparam int DIM_W    = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int CNT_W    = $clog2(NUM_DIMS + 1);
  localparam int EXT_W    = 32;
  localparam int STR_W    = 48;
  localparam int VAL_W    = 64;
  localparam int MUL_W    = 32;
  localparam int IN_W     = 2 * EXT_W + 2 * STR_W;
  localparam int OUT_W    = 8;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_NUM  = CNT_W'(NUM_DIMS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIMS - 1);

  typedef struct packed {
    logic [DIM_W-1:0] se;
    logic [DIM_W-1:0] ss;
    logic [DIM_W-1:0] de;
    logic [DIM_W-1:0] ds;
  } trvc_raddr_t;

  typedef struct packed {
    logic [EXT_W-1:0] se;
    logic [STR_W-1:0] ss;
    logic [EXT_W-1:0] de;
    logic [STR_W-1:0] ds;
  } trvc_rdata_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } trvc_mul_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [VAL_W-1:0] prod;
  } trvc_mul_rsp_t;

  // Maps an outermost-first dimension number onto the innermost-first storage slot.
  function automatic logic [DIM_W-1:0] rev_idx(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] r;
    r = CNT_LAST - x;
    return r[DIM_W-1:0];
  endfunction

endpackage

// ===== design/tensor_reshape_view_check_top.sv =====
// Top level of the tensor reshape view check with stream ports and result register.
// The block takes one transaction per dimension, innermost dimension first, one per cycle
// while idle; the transaction marked by tlast starts the check and yields one flag that says
// whether the destination extents and strides form a copy-free view of the source. Up to
// NUM_DIMS dimensions are held; extra transactions are ignored apart from their tlast.
// While the check runs, in_tready is low. The check walks the dimension steps, forms each
// product on the shared 32 by 32 bit multiplier (two partial products and a carry merge),
// and ends with a stride compare per dimension; its length is set by the number of products
// the dimension grouping requires. Transactions are taken while a finished flag still waits on
// the output; a check started meanwhile holds its flag until the output register is free.
module tensor_reshape_view_check_top
  import trvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // src_extent[31:0], src_stride[79:32], dst_extent[111:80], dst_stride[159:112]
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // can_view[0], zeros above
  output logic [OUT_W-1:0] out_tdata
);

  logic          in_acc;
  logic          seq_idle, res_valid, res_ready, res;
  logic          out_valid_r, out_valid_nxt;
  logic          can_view_r;
  trvc_raddr_t   raddr;
  trvc_rdata_t   rdata;
  trvc_mul_req_t mreq;
  trvc_mul_rsp_t mrsp;

  assign in_tready  = seq_idle;
  assign in_acc     = in_tvalid && in_tready;
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-1){1'b0}}, can_view_r};

  trvc_desc u_desc (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_acc),
    .wr_last    (in_tlast),
    .src_extent (in_tdata[EXT_W-1:0]),
    .src_stride (in_tdata[EXT_W+STR_W-1:EXT_W]),
    .dst_extent (in_tdata[2*EXT_W+STR_W-1:EXT_W+STR_W]),
    .dst_stride (in_tdata[IN_W-1:2*EXT_W+STR_W]),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  trvc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  trvc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && in_tlast),
    .idle      (seq_idle),
    .raddr     (raddr),
    .rdata     (rdata),
    .mreq      (mreq),
    .mrsp      (mrsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      can_view_r <= res;
    end
  end

endmodule

// ===== design/trvc_mul.sv =====
// Multi-cycle 64 by 32 bit multiplier with overflow flag, built on one 32 by 32 multiplier.
module trvc_mul
  import trvc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  trvc_mul_req_t req,
  output trvc_mul_rsp_t rsp
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_SUM  = 4'b1000
  } mstate_t;

  mstate_t               mstate_r, mstate_nxt;
  logic [VAL_W-1:0]      a_r;
  logic [MUL_W-1:0]      b_r;
  logic [2*MUL_W-1:0]    lo_r, hi_r;
  logic [MUL_W-1:0]      mop;
  logic [2*MUL_W-1:0]    pp;
  logic [MUL_W:0]        sum;
  logic                  ovf;

  always_comb begin
    mop = (mstate_r == M_LO) ? a_r[MUL_W-1:0] : a_r[VAL_W-1:MUL_W];
    pp  = (2*MUL_W)'(mop) * (2*MUL_W)'(b_r);
    sum = {1'b0, hi_r[MUL_W-1:0]} + {1'b0, lo_r[2*MUL_W-1:MUL_W]};
    ovf = (|hi_r[2*MUL_W-1:MUL_W]) | sum[MUL_W];
    rsp.done = (mstate_r == M_SUM);
    rsp.ovf  = ovf;
    rsp.prod = ovf ? {VAL_W{1'b1}} : {sum[MUL_W-1:0], lo_r[MUL_W-1:0]};
  end

  always_comb begin
    mstate_nxt = mstate_r;
    unique case (mstate_r)
      M_IDLE: if (req.start) mstate_nxt = M_LO;
      M_LO:   mstate_nxt = M_HI;
      M_HI:   mstate_nxt = M_SUM;
      M_SUM:  mstate_nxt = M_IDLE;
      default: mstate_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstate_r <= M_IDLE;
    end else begin
      mstate_r <= mstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mstate_r == M_IDLE && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (mstate_r == M_LO) begin
      lo_r <= pp;
    end
    if (mstate_r == M_HI) begin
      hi_r <= pp;
    end
  end

endmodule

// ===== design/trvc_desc.sv =====
// Descriptor storage: per-dimension extents and strides with the load counter.
module trvc_desc
  import trvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             wr_last,
  input  logic [EXT_W-1:0] src_extent,
  input  logic [STR_W-1:0] src_stride,
  input  logic [EXT_W-1:0] dst_extent,
  input  logic [STR_W-1:0] dst_stride,
  input  trvc_raddr_t      raddr,
  output trvc_rdata_t      rdata
);

  logic [EXT_W-1:0] se_r [NUM_DIMS];
  logic [STR_W-1:0] ss_r [NUM_DIMS];
  logic [EXT_W-1:0] de_r [NUM_DIMS];
  logic [STR_W-1:0] ds_r [NUM_DIMS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             room;

  assign room = (cnt_r < CNT_NUM);

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en) begin
      if (wr_last) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      se_r[cnt_r[DIM_W-1:0]] <= src_extent;
      ss_r[cnt_r[DIM_W-1:0]] <= src_stride;
      de_r[cnt_r[DIM_W-1:0]] <= dst_extent;
      ds_r[cnt_r[DIM_W-1:0]] <= dst_stride;
    end
  end

  always_comb begin
    rdata.se = se_r[raddr.se];
    rdata.ss = ss_r[raddr.ss];
    rdata.de = de_r[raddr.de];
    rdata.ds = ds_r[raddr.ds];
  end

endmodule

// ===== design/trvc_seq.sv =====
// Check sequencer: walks the dimensions, drives the shared multiplier and compares strides.
module trvc_seq
  import trvc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          idle,
  output trvc_raddr_t   raddr,
  input  trvc_rdata_t   rdata,
  output trvc_mul_req_t mreq,
  input  trvc_mul_rsp_t mrsp,
  output logic          res_valid,
  input  logic          res_ready,
  output logic          res
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_TOP   = 12'b000000000010,
    S_INS   = 12'b000000000100,
    S_INS_W = 12'b000000001000,
    S_CMP   = 12'b000000010000,
    S_GRP_W = 12'b000000100000,
    S_DNS   = 12'b000001000000,
    S_DNS_W = 12'b000010000000,
    S_RST   = 12'b000100000000,
    S_RST_W = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] iend_r, iend_nxt, oend_r, oend_nxt;
  logic [CNT_W-1:0] ib_r, ib_nxt, ob_r, ob_nxt, d_r, d_nxt;
  logic [VAL_W-1:0] iv_r, iv_nxt, ov_r, ov_nxt, cur_r, cur_nxt;
  logic             side_r, side_nxt, res_r, res_nxt;
  logic [VAL_W-1:0] drv_r [NUM_DIMS];
  logic             drv_clr, drv_we;
  logic [CNT_W-1:0] drv_idx;
  logic [VAL_W-1:0] drv_wd;
  logic [CNT_W-1:0] se_x, ss_x, de_x, ds_x;
  logic [VAL_W-1:0] se_v, ss_v, de_v, ds_v;

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign se_v = VAL_W'(rdata.se);
  assign ss_v = VAL_W'(rdata.ss);
  assign de_v = VAL_W'(rdata.de);
  assign ds_v = VAL_W'(rdata.ds);

  always_comb begin
    se_x = '0;
    ss_x = '0;
    de_x = '0;
    ds_x = '0;
    unique case (state_r)
      S_TOP: begin
        se_x = iend_r - CNT_ONE;
        de_x = oend_r - CNT_ONE;
      end
      S_INS: begin
        se_x = iend_r;
        ss_x = iend_r;
      end
      S_CMP: begin
        se_x = ib_r - CNT_ONE;
        de_x = ob_r - CNT_ONE;
        ss_x = ib_r;
      end
      S_DNS: begin
        se_x = d_r;
        ss_x = (d_r > ib_r) ? d_r : iend_r - CNT_ONE;
      end
      S_DNS_W: ss_x = d_r - CNT_ONE;
      S_RST:   de_x = d_r;
      S_FIN:   ds_x = d_r;
      default: ;
    endcase
    raddr.se = rev_idx(se_x);
    raddr.ss = rev_idx(ss_x);
    raddr.de = rev_idx(de_x);
    raddr.ds = rev_idx(ds_x);
  end

  always_comb begin
    state_nxt = state_r;
    iend_nxt  = iend_r;
    oend_nxt  = oend_r;
    ib_nxt    = ib_r;
    ob_nxt    = ob_r;
    d_nxt     = d_r;
    iv_nxt    = iv_r;
    ov_nxt    = ov_r;
    cur_nxt   = cur_r;
    side_nxt  = side_r;
    res_nxt   = res_r;
    drv_clr   = 1'b0;
    drv_we    = 1'b0;
    drv_idx   = '0;
    drv_wd    = '0;
    mreq      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          drv_clr   = 1'b1;
          iend_nxt  = CNT_NUM;
          oend_nxt  = CNT_NUM;
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        priority if (iend_r == '0 && oend_r == '0) begin
          d_nxt     = '0;
          state_nxt = S_FIN;
        end else if (iend_r != '0 && rdata.se == EXT_W'(1)) begin
          iend_nxt = iend_r - CNT_ONE;
        end else if (oend_r != '0 && rdata.de == EXT_W'(1)) begin
          if (iend_r == CNT_NUM) begin
            drv_we   = 1'b1;
            drv_idx  = oend_r - CNT_ONE;
            drv_wd   = VAL_W'(1);
            oend_nxt = oend_r - CNT_ONE;
          end else begin
            state_nxt = S_INS;
          end
        end else if (iend_r == '0 || oend_r == '0) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          ib_nxt    = iend_r - CNT_ONE;
          ob_nxt    = oend_r - CNT_ONE;
          iv_nxt    = se_v;
          ov_nxt    = de_v;
          state_nxt = S_CMP;
        end
      end
      S_INS: begin
        mreq.start = 1'b1;
        mreq.a     = ss_v;
        mreq.b     = rdata.se;
        state_nxt  = S_INS_W;
      end
      S_INS_W: begin
        if (mrsp.done) begin
          drv_we    = 1'b1;
          drv_idx   = oend_r - CNT_ONE;
          drv_wd    = mrsp.prod;
          oend_nxt  = oend_r - CNT_ONE;
          state_nxt = S_TOP;
        end
      end
      S_CMP: begin
        priority if (iv_r == ov_r) begin
          if (ib_r + CNT_ONE == iend_r && ob_r + CNT_ONE == oend_r) begin
            drv_we    = 1'b1;
            drv_idx   = ob_r;
            drv_wd    = ss_v;
            iend_nxt  = ib_r;
            oend_nxt  = ob_r;
            state_nxt = S_TOP;
          end else begin
            d_nxt     = iend_r - CNT_ONE;
            state_nxt = S_DNS;
          end
        end else if (iv_r < ov_r) begin
          if (ib_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            ib_nxt     = ib_r - CNT_ONE;
            mreq.start = 1'b1;
            mreq.a     = iv_r;
            mreq.b     = rdata.se;
            side_nxt   = 1'b0;
            state_nxt  = S_GRP_W;
          end
        end else begin
          if (ob_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            ob_nxt     = ob_r - CNT_ONE;
            mreq.start = 1'b1;
            mreq.a     = ov_r;
            mreq.b     = rdata.de;
            side_nxt   = 1'b1;
            state_nxt  = S_GRP_W;
          end
        end
      end
      S_GRP_W: begin
        if (mrsp.done) begin
          if (mrsp.ovf) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            if (side_r) begin
              ov_nxt = mrsp.prod;
            end else begin
              iv_nxt = mrsp.prod;
            end
            state_nxt = S_CMP;
          end
        end
      end
      S_DNS: begin
        if (d_r > ib_r) begin
          mreq.start = 1'b1;
          mreq.a     = ss_v;
          mreq.b     = rdata.se;
          state_nxt  = S_DNS_W;
        end else begin
          cur_nxt   = ss_v;
          d_nxt     = oend_r - CNT_ONE;
          state_nxt = S_RST;
        end
      end
      S_DNS_W: begin
        if (mrsp.done) begin
          if (mrsp.ovf || mrsp.prod != ss_v) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            d_nxt     = d_r - CNT_ONE;
            state_nxt = S_DNS;
          end
        end
      end
      S_RST: begin
        drv_we  = 1'b1;
        drv_idx = d_r;
        drv_wd  = cur_r;
        if (d_r == ob_r) begin
          iend_nxt  = ib_r;
          oend_nxt  = ob_r;
          state_nxt = S_TOP;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = cur_r;
          mreq.b     = rdata.de;
          state_nxt  = S_RST_W;
        end
      end
      S_RST_W: begin
        if (mrsp.done) begin
          cur_nxt   = mrsp.prod;
          d_nxt     = d_r - CNT_ONE;
          state_nxt = S_RST;
        end
      end
      S_FIN: begin
        priority if (drv_r[d_r[DIM_W-1:0]] != ds_v) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (d_r == CNT_LAST) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          d_nxt = d_r + CNT_ONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iend_r <= iend_nxt;
    oend_r <= oend_nxt;
    ib_r   <= ib_nxt;
    ob_r   <= ob_nxt;
    d_r    <= d_nxt;
    iv_r   <= iv_nxt;
    ov_r   <= ov_nxt;
    cur_r  <= cur_nxt;
    side_r <= side_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (drv_clr) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        drv_r[i] <= '0;
      end
    end else if (drv_we) begin
      drv_r[drv_idx[DIM_W-1:0]] <= drv_wd;
    end
  end

endmodule

// ===== dv/tensor_reshape_view_check_top_tb.sv =====
// Self-checking stream testbench for the tensor reshape view check, with its own view predictor.
`timescale 1ns / 1ps

module tensor_reshape_view_check_top_tb
  import trvc_pkg::*;
();

  localparam int EXP_DEPTH = 2048;
  localparam int LOADED_GOAL = 950;
  localparam int TAIL_CYCLES = 100;
  localparam logic [EXT_W-1:0] MAXE = {EXT_W{1'b1}};
  localparam logic [STR_W-1:0] MAXS = {STR_W{1'b1}};
  localparam logic [VAL_W-1:0] SAT = {VAL_W{1'b1}};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  typedef struct {
    logic [EXT_W-1:0] src_extent;
    logic [STR_W-1:0] src_stride;
    logic [EXT_W-1:0] dst_extent;
    logic [STR_W-1:0] dst_stride;
    logic             last;
    logic             hold_for_drain;
  } dim_item_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  dim_item_t pending_dims[$];
  int        n_stim_items = 0;
  int        n_loaded_stim = 0;
  int        n_dims_accepted = 0;
  int        n_predicted = 0;
  int        n_checked = 0;
  int        n_errors = 0;
  logic      view_expected [EXP_DEPTH];

  logic [EXT_W-1:0] held_src_ext [NUM_DIMS];
  logic [STR_W-1:0] held_src_str [NUM_DIMS];
  logic [EXT_W-1:0] held_dst_ext [NUM_DIMS];
  logic [STR_W-1:0] held_dst_str [NUM_DIMS];
  int               dims_held = 0;

  logic [EXT_W-1:0] b_se [NUM_DIMS];
  logic [STR_W-1:0] b_ss [NUM_DIMS];
  logic [EXT_W-1:0] b_de [NUM_DIMS];
  logic [STR_W-1:0] b_ds [NUM_DIMS];

  tensor_reshape_view_check_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Full 64 by 64 product; on overflow the product reads as all ones.
  function automatic logic mul_check(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                     output logic [VAL_W-1:0] prod);
    logic [2*VAL_W-1:0] full;
    full = (2*VAL_W)'(a) * (2*VAL_W)'(b);
    if (full[2*VAL_W-1:VAL_W] != '0) begin
      prod = SAT;
      return 1'b1;
    end
    prod = full[VAL_W-1:0];
    return 1'b0;
  endfunction

  function automatic logic view_is_valid();
    logic [VAL_W-1:0] s_ext [NUM_DIMS];
    logic [VAL_W-1:0] s_str [NUM_DIMS];
    logic [VAL_W-1:0] d_ext [NUM_DIMS];
    logic [VAL_W-1:0] d_str [NUM_DIMS];
    logic [VAL_W-1:0] drv [NUM_DIMS];
    logic [VAL_W-1:0] iv, ov, cur, p;
    logic             ovf;
    int               ib, iend, ob, oend, d;
    iend = NUM_DIMS;
    oend = NUM_DIMS;
    ib = NUM_DIMS;
    ob = NUM_DIMS;
    ovf = 1'b0;
    // Work arrays are ordered outermost dimension first.
    for (d = 0; d < NUM_DIMS; d++) begin
      s_ext[d] = VAL_W'(held_src_ext[NUM_DIMS-1-d]);
      s_str[d] = VAL_W'(held_src_str[NUM_DIMS-1-d]);
      d_ext[d] = VAL_W'(held_dst_ext[NUM_DIMS-1-d]);
      d_str[d] = VAL_W'(held_dst_str[NUM_DIMS-1-d]);
      drv[d] = '0;
    end
    while (iend != 0 || oend != 0) begin
      if (iend > 0 && s_ext[iend-1] == VAL_W'(1)) begin
        ib = iend - 1;
        ob = oend;
      end else if (oend > 0 && d_ext[oend-1] == VAL_W'(1)) begin
        ib = iend;
        ob = oend - 1;
        if (ib == NUM_DIMS) begin
          drv[ob] = VAL_W'(1);
        end else begin
          void'(mul_check(s_str[ib], s_ext[ib], drv[ob]));
        end
      end else begin
        if (iend == 0 || oend == 0) return 1'b0;
        ib = iend - 1;
        ob = oend - 1;
        iv = s_ext[ib];
        ov = d_ext[ob];
        while (iv != ov) begin
          if (iv < ov) begin
            if (ib == 0) return 1'b0;
            ib--;
            ovf = mul_check(iv, s_ext[ib], iv);
          end else begin
            if (ob == 0) return 1'b0;
            ob--;
            ovf = mul_check(ov, d_ext[ob], ov);
          end
          if (ovf) return 1'b0;
        end
        if (ib + 1 == iend && ob + 1 == oend) begin
          drv[ob] = s_str[ib];
        end else begin
          for (d = iend - 1; d > ib; d--) begin
            ovf = mul_check(s_ext[d], s_str[d], p);
            if (ovf || p != s_str[d-1]) return 1'b0;
          end
          cur = s_str[iend-1];
          for (d = oend - 1; d >= ob; d--) begin
            drv[d] = cur;
            void'(mul_check(cur, d_ext[d], cur));
          end
        end
      end
      iend = ib;
      oend = ob;
    end
    for (d = 0; d < NUM_DIMS; d++) begin
      if (drv[d] != d_str[d]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Stores one dimension; a transaction with tlast yields the view verdict.
  function automatic logic take_dimension(input dim_item_t it, output logic verdict);
    verdict = 1'b0;
    if (dims_held < NUM_DIMS) begin
      held_src_ext[dims_held] = it.src_extent;
      held_src_str[dims_held] = it.src_stride;
      held_dst_ext[dims_held] = it.dst_extent;
      held_dst_str[dims_held] = it.dst_stride;
      dims_held++;
    end
    if (!it.last) return 1'b0;
    verdict = view_is_valid();
    dims_held = 0;
    return 1'b1;
  endfunction

  task automatic set_dim(input int k, input logic [EXT_W-1:0] se, input logic [STR_W-1:0] ss,
                         input logic [EXT_W-1:0] de, input logic [STR_W-1:0] ds);
    b_se[k] = se;
    b_ss[k] = ss;
    b_de[k] = de;
    b_ds[k] = ds;
  endtask

  // Queues n transactions; those past NUM_DIMS carry random data that the block drops.
  task automatic queue_descriptor(input int n, input logic drain);
    dim_item_t it;
    for (int k = 0; k < n; k++) begin
      if (k < NUM_DIMS) begin
        it.src_extent = b_se[k];
        it.src_stride = b_ss[k];
        it.dst_extent = b_de[k];
        it.dst_stride = b_ds[k];
      end else begin
        it.src_extent = $urandom;
        it.src_stride = STR_W'({$urandom, $urandom});
        it.dst_extent = $urandom;
        it.dst_stride = STR_W'({$urandom, $urandom});
      end
      it.last = (k == n - 1);
      it.hold_for_drain = drain && (k == 0);
      pending_dims.push_back(it);
    end
    n_stim_items += n;
    n_loaded_stim += (n < NUM_DIMS) ? n : NUM_DIMS;
  endtask

  // Builds a dense source and a destination that regroups the same factors, then
  // mostly leaves it valid and otherwise breaks it or replaces it with noise.
  task automatic build_reshape();
    int unsigned f, nf, j, k, base, kind;
    for (k = 0; k < NUM_DIMS; k++) begin
      b_se[k] = 1;
      b_de[k] = 1;
    end
    j = 0;
    for (k = 0; k < NUM_DIMS; k++) begin
      nf = $urandom_range(0, 3);
      repeat (nf) begin
        case ($urandom_range(0, 4))
          0: f = 2;
          1: f = 3;
          2: f = 4;
          3: f = 5;
          default: f = 7;
        endcase
        b_se[k] = b_se[k] * f;
        while (j < NUM_DIMS - 1 && $urandom_range(0, 2) == 0) j++;
        b_de[j] = b_de[j] * f;
      end
    end
    base = $urandom_range(0, 1) ? 1 : $urandom_range(1, 64);
    b_ss[0] = STR_W'(base);
    b_ds[0] = STR_W'(base);
    for (k = 1; k < NUM_DIMS; k++) begin
      b_ss[k] = b_ss[k-1] * STR_W'(b_se[k-1]);
      b_ds[k] = b_ds[k-1] * STR_W'(b_de[k-1]);
    end
    kind = $urandom_range(0, 99);
    if (kind >= 55 && kind < 70) begin
      k = $urandom_range(0, NUM_DIMS - 1);
      b_ds[k] = b_ds[k] ^ (STR_W'(1) << $urandom_range(0, STR_W - 1));
    end else if (kind >= 70 && kind < 80) begin
      k = $urandom_range(1, NUM_DIMS - 1);
      b_ss[k] = b_ss[k] + STR_W'($urandom_range(1, 8));
    end else if (kind >= 80 && kind < 90) begin
      for (k = 0; k < NUM_DIMS; k++) begin
        b_se[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4);
        b_ss[k] = STR_W'({$urandom, $urandom});
        b_de[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4);
        b_ds[k] = STR_W'({$urandom, $urandom});
      end
    end else if (kind >= 90) begin
      for (k = 0; k < NUM_DIMS; k++) begin
        b_se[k] = $urandom_range(0, 3);
        b_ss[k] = STR_W'($urandom_range(0, 8));
        b_de[k] = $urandom_range(0, 3);
        b_ds[k] = STR_W'($urandom_range(0, 8));
      end
    end
  endtask

  initial begin : fill_stimulus
    int r, n;
    // The first descriptor fills every slot so that no slot is read unwritten.
    set_dim(0, 2, 1, 2, 1);
    set_dim(1, 3, 2, 3, 2);
    set_dim(2, 4, 6, 4, 6);
    set_dim(3, 5, 24, 5, 24);
    queue_descriptor(4, 1'b0);
    set_dim(0, 2, 1, 6, 1);
    set_dim(1, 3, 2, 20, 6);
    set_dim(2, 4, 6, 1, 120);
    set_dim(3, 5, 24, 1, 120);
    queue_descriptor(4, 1'b1);
    set_dim(0, 0, 0, 0, 0);
    queue_descriptor(1, 1'b0);
    set_dim(0, 1, 0, MAXE, MAXS);
    set_dim(1, 1, 0, 1, MAXS);
    set_dim(2, 1, 0, 1, MAXS);
    set_dim(3, MAXE, MAXS, 1, MAXS);
    queue_descriptor(4, 1'b0);
    for (int k = 0; k < NUM_DIMS; k++) set_dim(k, 32'h10000, 1, MAXE, 0);
    queue_descriptor(4, 1'b0);
    set_dim(0, MAXE, MAXS, 2, 1);
    set_dim(1, 2, 1, MAXE, 2);
    set_dim(2, 1, 1, 1, 1);
    set_dim(3, 1, 1, 1, 1);
    queue_descriptor(6, 1'b0);
    set_dim(0, MAXE, MAXS, MAXE, MAXS);
    queue_descriptor(1, 1'b0);
    while (n_loaded_stim < LOADED_GOAL) begin
      build_reshape();
      r = $urandom_range(0, 99);
      if (r < 80) n = NUM_DIMS;
      else if (r < 92) n = $urandom_range(1, NUM_DIMS - 1);
      else n = $urandom_range(NUM_DIMS + 1, NUM_DIMS + 3);
      queue_descriptor(n, $urandom_range(0, 39) == 0);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin : drive_dims
    logic      fire, next_valid, produced, verdict;
    int        gap_left, burst_left;
    dim_item_t cur_dim;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      fire = in_tvalid && in_tready;
      next_valid = in_tvalid && !fire;
      produced = 1'b0;
      if (fire) begin
        produced = take_dimension(cur_dim, verdict);
        if (produced) begin
          view_expected[n_predicted % EXP_DEPTH] <= verdict;
          n_predicted <= n_predicted + 1;
        end
        n_dims_accepted <= n_dims_accepted + 1;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_dims.size() != 0 &&
                     !(pending_dims[0].hold_for_drain &&
                       (n_predicted + int'(produced) != n_checked))) begin
          cur_dim = pending_dims.pop_front();
          next_valid = 1'b1;
          in_tdata <= {cur_dim.dst_stride, cur_dim.dst_extent,
                       cur_dim.src_stride, cur_dim.src_extent};
          in_tlast <= cur_dim.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      in_tvalid <= next_valid;
    end
  end

  always @(posedge clk) begin : pace_results
    logic     ready_next;
    int       hold_left, mode_left, phase;
    logic     first_hold_done, second_hold_done;
    rx_mode_t mode;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      phase = 0;
      first_hold_done = 1'b0;
      second_hold_done = 1'b0;
      mode = RX_OPEN;
    end else begin
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!first_hold_done && n_checked >= 30) begin
        first_hold_done = 1'b1;
        hold_left = 400;
        ready_next = 1'b0;
      end else if (!second_hold_done && n_checked >= 120) begin
        second_hold_done = 1'b1;
        hold_left = 300;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (mode)
          RX_OPEN:   ready_next = 1'b1;
          RX_COIN:   ready_next = $urandom_range(0, 1);
          RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:   ready_next = (phase % 5) < 2;
        endcase
      end
      out_tready <= ready_next;
    end
  end

  always @(posedge clk) begin : check_verdicts
    if (rst_n && out_tvalid && out_tready) begin
      if (n_checked >= n_predicted) begin
        $error("can_view: no result expected, actual %0d", out_tdata[0]);
        n_errors++;
      end else begin
        if (out_tdata[0] !== view_expected[n_checked % EXP_DEPTH]) begin
          $error("can_view mismatch: expected %0d, actual %0d",
                 view_expected[n_checked % EXP_DEPTH], out_tdata[0]);
          n_errors++;
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  initial begin : finish_run
    do @(posedge clk);
    while (!(rst_n && n_stim_items > 0 && n_dims_accepted == n_stim_items &&
             n_checked == n_predicted));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_checked != n_predicted) begin
      $error("can_view: %0d expected results never arrived", n_predicted - n_checked);
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("PASS tensor_reshape_view_check_top");
    end else begin
      $display("FAIL tensor_reshape_view_check_top");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAIL tensor_reshape_view_check_top");
    $finish;
  end

endmodule
